### rtl/pfx_eval_pkg.sv
package pfx_eval_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_STACK_DEPTH = 32;

  // ASCII codes
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // status codes
  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_EMPTY = 3'd1;
  localparam logic [2:0] STS_UNDER = 3'd2;
  localparam logic [2:0] STS_OVER  = 3'd3;
  localparam logic [2:0] STS_DIVZ  = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_WAIT_ALU,
    S_QRD,
    S_QOUT
  } state_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_POW
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_DIVFIN,
    A_POW
  } alu_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage

### rtl/pfx_eval_alu.sv
module pfx_eval_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfx_eval_pkg::alu_req_t              req,
  input  logic [pfx_eval_pkg::DATA_W-1:0]     a,
  input  logic [pfx_eval_pkg::DATA_W-1:0]     b,
  output pfx_eval_pkg::alu_rsp_t              rsp,
  output logic [pfx_eval_pkg::DATA_W-1:0]     result
);
  import pfx_eval_pkg::*;

  localparam int CNTW = $clog2(DATA_W);

  alu_state_t          state_r, state_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;     // product / power result / quotient out
  logic [DATA_W-1:0]   x_r, x_nxt;         // power base, or dividend shifting into quotient
  logic [DATA_W-1:0]   y_r, y_nxt;         // partial remainder
  logic [DATA_W-1:0]   z_r, z_nxt;         // divisor magnitude
  logic [DATA_W-2:0]   e_r, e_nxt;         // remaining exponent bits
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic                phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic                done_r, done_nxt;

  logic [DATA_W-1:0]   mul_x, mul_y, prod;
  logic [DATA_W:0]     trial;

  // the one multiplier, low word only
  assign prod  = mul_x * mul_y;
  assign trial = {y_r, x_r[DATA_W-1]} - {1'b0, z_r};

  always_comb begin
    if (state_r == A_IDLE) begin
      mul_x = a;
      mul_y = b;
    end else if (state_r == A_POW && !phase_r) begin
      mul_x = acc_r;
      mul_y = x_r;
    end else begin
      mul_x = x_r;
      mul_y = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    e_r     <= e_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    neg_r   <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    e_nxt     = e_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            ALU_MUL: begin
              acc_nxt  = prod;
              done_nxt = 1'b1;
            end
            ALU_DIV: begin
              x_nxt     = a[DATA_W-1] ? (~a + 1'b1) : a;
              z_nxt     = b[DATA_W-1] ? (~b + 1'b1) : b;
              y_nxt     = '0;
              neg_nxt   = a[DATA_W-1] ^ b[DATA_W-1];
              cnt_nxt   = '0;
              state_nxt = A_DIV;
            end
            ALU_POW: begin
              acc_nxt   = DATA_W'(1);
              x_nxt     = a;
              e_nxt     = b[DATA_W-2:0];
              phase_nxt = 1'b0;
              state_nxt = A_POW;
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      A_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[DATA_W]) begin
          y_nxt = trial[DATA_W-1:0];
          x_nxt = {x_r[DATA_W-2:0], 1'b1};
        end else begin
          y_nxt = {y_r[DATA_W-2:0], x_r[DATA_W-1]};
          x_nxt = {x_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DATA_W-1)) begin
          state_nxt = A_DIVFIN;
        end
      end
      A_DIVFIN: begin
        acc_nxt   = neg_r ? (~x_r + 1'b1) : x_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      A_POW: begin
        // square and multiply, LSB first: multiply step then square step
        if (e_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else if (!phase_r) begin
          if (e_r[0]) begin
            acc_nxt = prod;
          end
          phase_nxt = 1'b1;
        end else begin
          x_nxt     = prod;
          e_nxt     = e_r >> 1;
          phase_nxt = 1'b0;
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign result   = acc_r;

endmodule

### rtl/postfix_expression_evaluator_core.sv
// Postfix (RPN) evaluator: one ASCII character per in_ch transfer. Digit runs build
// unsigned 32-bit numbers (wrapping), any other character closes the run and pushes it.
// + - * / ^ pop b then a and push a op b in 32-bit two's complement; '?' returns the top
// of stack with a status (0 ok, 1 empty, 2 underflow, 3 overflow, 4 divide by zero,
// first error wins) and clears the stack. Digits and other non-operator characters are
// taken in S_IDLE. Operators pass S_RD_B, S_RD_A and S_EXEC, where + and - end; * waits
// in S_WAIT_ALU on the combinational 32x32 multiplier, / on a radix-2 restoring divider
// (one quotient bit per cycle), ^ on one multiply and one square step of the shared
// multiplier per exponent bit up to its highest set bit; / by zero and ^ with a negative
// exponent end in S_EXEC. '?' passes S_QRD and S_QOUT, waiting while the output register
// is full and stalled. The operand stack is a single-port-write memory with a registered
// read, so b and a are fetched in turn. in_stall is high while an item is in progress.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = pfx_eval_pkg::DEF_STACK_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             in_ch,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pfx_eval_pkg::DATA_W-1:0] out_value,
  output logic [2:0]                             out_status
);
  import pfx_eval_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] stack_mem_r [STACK_DEPTH];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] num_r, num_nxt;
  logic              innum_r, innum_nxt;
  logic [2:0]        err_r, err_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [2:0]        out_status_r, out_status_nxt;

  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  logic [CW-1:0]     cnt_m1, cnt_m2, cnt_tmp;
  logic [2:0]        err_tmp;
  logic              is_digit, is_op;
  op_t               op_dec;
  logic [7:0]        digit;
  logic [DATA_W-1:0] a_val;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_result;

  function automatic logic [2:0] keep_first(input logic [2:0] cur, input logic [2:0] code);
    return (cur == STS_OK) ? code : cur;
  endfunction

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign digit    = in_ch - CH_ZERO;
  assign a_val    = rd_data_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    is_op  = 1'b1;
    op_dec = OP_ADD;
    unique case (in_ch)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      CH_CARET: op_dec = OP_POW;
      default:  is_op  = 1'b0;
    endcase
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem_r[waddr] <= wdata;
    end
    rd_data_r <= stack_mem_r[rd_addr];
  end

  pfx_eval_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (a_val),
    .b      (b_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      num_r       <= '0;
      innum_r     <= 1'b0;
      err_r       <= STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      num_r       <= num_nxt;
      innum_r     <= innum_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    num_nxt        = num_r;
    innum_nxt      = innum_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    b_nxt          = b_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    rd_addr        = cnt_m1[AW-1:0];
    we             = 1'b0;
    waddr          = cnt_r[AW-1:0];
    wdata          = num_r;
    alu_req.start  = 1'b0;
    alu_req.op     = ALU_MUL;
    cnt_tmp        = cnt_r;
    err_tmp        = err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_digit) begin
            // num * 10 + digit
            num_nxt   = (num_r << 3) + (num_r << 1) + DATA_W'(digit[3:0]);
            innum_nxt = 1'b1;
          end else begin
            if (innum_r) begin
              if (cnt_r == CW'(STACK_DEPTH)) begin
                err_tmp = keep_first(err_tmp, STS_OVER);
              end else begin
                we      = 1'b1;
                cnt_tmp = cnt_r + CW'(1);
              end
              num_nxt   = '0;
              innum_nxt = 1'b0;
            end
            if (is_op) begin
              if (cnt_tmp < CW'(2)) begin
                err_tmp = keep_first(err_tmp, STS_UNDER);
              end else begin
                op_nxt    = op_dec;
                state_nxt = S_RD_B;
              end
            end else if (in_ch == CH_QUERY) begin
              state_nxt = S_QRD;
            end
            cnt_nxt = cnt_tmp;
            err_nxt = err_tmp;
          end
        end
      end
      S_RD_B: begin
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        rd_addr   = cnt_m2[AW-1:0];
        b_nxt     = rd_data_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // result replaces a; stack shrinks by one
        waddr     = cnt_m2[AW-1:0];
        state_nxt = S_IDLE;
        unique case (op_r)
          OP_ADD: begin
            we      = 1'b1;
            wdata   = a_val + b_r;
            cnt_nxt = cnt_m1;
          end
          OP_SUB: begin
            we      = 1'b1;
            wdata   = a_val - b_r;
            cnt_nxt = cnt_m1;
          end
          OP_MUL: begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MUL;
            state_nxt     = S_WAIT_ALU;
          end
          OP_DIV: begin
            if (b_r == '0) begin
              we      = 1'b1;
              wdata   = '0;
              cnt_nxt = cnt_m1;
              err_nxt = keep_first(err_r, STS_DIVZ);
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = ALU_DIV;
              state_nxt     = S_WAIT_ALU;
            end
          end
          OP_POW: begin
            if (b_r[DATA_W-1]) begin
              // negative exponent, truncated toward zero
              we      = 1'b1;
              cnt_nxt = cnt_m1;
              if (a_val == DATA_W'(1)) begin
                wdata = DATA_W'(1);
              end else if (a_val == '1) begin
                wdata = b_r[0] ? '1 : DATA_W'(1);
              end else begin
                wdata = '0;
                if (a_val == '0) begin
                  err_nxt = keep_first(err_r, STS_DIVZ);
                end
              end
            end else begin
              alu_req.start = 1'b1;
              alu_req.op    = ALU_POW;
              state_nxt     = S_WAIT_ALU;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WAIT_ALU: begin
        waddr = cnt_m2[AW-1:0];
        wdata = alu_result;
        if (alu_rsp.done) begin
          we        = 1'b1;
          cnt_nxt   = cnt_m1;
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (cnt_r == '0) ? '0 : rd_data_r;
          if (err_r != STS_OK) begin
            out_status_nxt = err_r;
          end else if (cnt_r == '0) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            out_status_nxt = STS_OK;
          end
          cnt_nxt   = '0;
          err_nxt   = STS_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_two_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_B) |-> (cnt_r >= CW'(2)))
    else $error("operator started without two operands");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_QOUT))
    else $error("result raised outside query step");

  a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> (state_r == S_WAIT_ALU))
    else $error("arithmetic unit finished while sequencer not waiting");
`endif

endmodule

### test/postfix_expression_evaluator_core_tb.sv
module postfix_expression_evaluator_core_tb;
  import pfx_eval_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam int RAND_CHARS = 800;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } rpn_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_ch = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic [2:0]        out_status;

  postfix_expression_evaluator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pending characters and expected expression results
  logic [7:0]  char_q[$];
  rpn_result_t expected_results[$];

  // evaluator state mirror
  logic [31:0] calc_stack[0:DEPTH-1];
  int          calc_depth;
  logic [31:0] calc_acc;
  logic        calc_in_num;
  logic [2:0]  calc_err;

  int n_sent;
  int n_checked;
  int n_errors;
  int status_seen[0:7];

  // ---------------------------------------------------------------- predictor
  function automatic logic is_operator(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_CARET;
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] a, logic [31:0] b);
    logic [31:0] r, base, e;
    if (b[31]) begin
      if (a == 32'd1) return 32'd1;
      if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    r    = 32'd1;
    base = a;
    e    = b;
    while (e != 0) begin
      if (e[0]) r = r * base;
      base = base * base;
      e    = e >> 1;
    end
    return r;
  endfunction

  task automatic calc_flag(input logic [2:0] code);
    if (calc_err == STS_OK) calc_err = code;
  endtask

  task automatic calc_push(input logic [31:0] v);
    if (calc_depth >= DEPTH) begin
      calc_flag(STS_OVER);
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endtask

  task automatic calc_feed(input logic [7:0] c);
    logic [31:0] a, b, r;
    rpn_result_t res;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      calc_acc    = calc_acc * 32'd10 + {24'd0, c - CH_ZERO};
      calc_in_num = 1'b1;
    end else begin
      if (calc_in_num) begin
        calc_push(calc_acc);
        calc_acc    = '0;
        calc_in_num = 1'b0;
      end
      if (is_operator(c)) begin
        if (calc_depth < 2) begin
          calc_flag(STS_UNDER);
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          calc_depth -= 2;
          case (c)
            CH_PLUS:  r = a + b;
            CH_MINUS: r = a - b;
            CH_STAR:  r = a * b;
            CH_SLASH: begin
              if (b == 0) begin
                calc_flag(STS_DIVZ);
                r = '0;
              end else begin
                r = trunc_div(a, b);
              end
            end
            default: begin
              if (b[31] && a == 0) calc_flag(STS_DIVZ);
              r = int_power(a, b);
            end
          endcase
          calc_push(r);
        end
      end else if (c == CH_QUERY) begin
        res.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
        if (calc_err != STS_OK) res.status = calc_err;
        else if (calc_depth == 0) res.status = STS_EMPTY;
        else res.status = STS_OK;
        expected_results.push_back(res);
        calc_depth  = 0;
        calc_acc    = '0;
        calc_in_num = 1'b0;
        calc_err    = STS_OK;
      end
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic is_plain(logic [7:0] c);
    return !(c >= CH_ZERO && c <= CH_NINE) && !is_operator(c) && c != CH_QUERY;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  task automatic add_separator();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      char_q.push_back(CH_SPACE);
    end else begin
      c = 8'($urandom_range(0, 255));
      while (!is_plain(c)) c = 8'($urandom_range(0, 255));
      char_q.push_back(c);
      if ($urandom_range(0, 3) == 0) char_q.push_back(CH_SPACE);
    end
  endtask

  task automatic add_number();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) add_text($sformatf("%0d", $urandom_range(0, 9)));
    else if (kind < 7) add_text($sformatf("%0d", $urandom_range(0, 999)));
    else if (kind < 9) add_text($sformatf("%0d", $urandom));
    else begin
      // runs long enough that the accumulator can wrap
      for (int i = 0; i < $urandom_range(11, 20); i++)
        char_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_operator();
    logic [7:0] ops[5];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
    char_q.push_back(ops[$urandom_range(0, 4)]);
  endtask

  // one expression ending in '?'; mostly well formed
  task automatic add_expression();
    int kind, depth, n_ops, fill;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      depth = 0;
      n_ops = $urandom_range(1, 8);
      fill  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : 0;
      for (int i = 0; i < fill; i++) begin
        add_number();
        add_separator();
        depth++;
      end
      while (n_ops > 0) begin
        if (depth < 2 || $urandom_range(0, 2) == 0) begin
          add_number();
          depth++;
          if ($urandom_range(0, 1) == 0) add_separator();
          else if (depth < 2) add_separator();
        end else begin
          add_operator();
          depth--;
          n_ops--;
          if ($urandom_range(0, 2) == 0) char_q.push_back(CH_SPACE);
        end
      end
    end else if (kind < 85) begin
      for (int i = 0; i < $urandom_range(1, 8); i++) begin
        if ($urandom_range(0, 1) == 0) begin
          add_number();
          add_separator();
        end else begin
          add_operator();
        end
      end
    end else begin
      for (int i = 0; i < $urandom_range(3, 15); i++)
        char_q.push_back(8'($urandom_range(0, 255)));
    end
    char_q.push_back(CH_QUERY);
  endtask

  task automatic build_stimulus();
    add_text("?");
    add_text("4294967295 1+?");
    add_text("12 5-?5 12-?");
    add_text("65536 65536*?");
    add_text("7 2/?0 7- 2/?7 0 2-/?");
    add_text("2147483648 0 1-/?");
    add_text("5 0/?");
    add_text("3 4^?0 0^?2 0 1-^?1 0 3-^?");
    add_text("0 1- 0 3-^?0 1- 0 2-^?0 0 1-^?");
    add_text("+?1+2 3+?5 0/+?");
    add_text("99999999999?42?");
    add_text("1");
    char_q.push_back(8'h00);
    add_text("2");
    char_q.push_back(8'hFF);
    add_text("+?");
    for (int i = 0; i < DEPTH + 2; i++) add_text("7 ");
    add_text("+?");
    while (char_q.size() < RAND_CHARS) add_expression();
  endtask

  // ---------------------------------------------------------------- driver
  int   gap_left;
  logic idling_on = 1'b0;
  logic hold_req = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_ch     <= 8'h00;
      gap_left  <= 0;
      idling_on <= 1'b0;
      hold_req  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        calc_feed(in_ch);
        n_sent++;
      end
      idling_on <= (((n_sent / 150) % 3) != 2) && (char_q.size() > 120);
      hold_req  <= (n_sent >= 300);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 11);
        end else if (char_q.size() != 0) begin
          in_valid <= 1'b1;
          in_ch    <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so '?' backs up into the input
  int   hold_left;
  logic hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  int stall_left;

  always @(posedge clk) begin
    rpn_result_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: value %0d status %0d", out_value, out_status);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          status_seen[out_status]++;
          if (out_value !== want.value || out_status !== want.status) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d: value exp %0d got %0d, status exp %0d got %0d",
                       n_checked, want.value, out_value, want.status, out_status);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- run control
  initial begin
    calc_depth  = 0;
    calc_acc    = '0;
    calc_in_num = 1'b0;
    calc_err    = STS_OK;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    build_stimulus();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d characters sent, %0d expressions checked", n_sent, n_checked);
    $display("status mix: ok %0d, empty %0d, underflow %0d, overflow %0d, div by zero %0d",
             status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_UNDER],
             status_seen[STS_OVER], status_seen[STS_DIVZ]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("postfix_expression_evaluator_core: match");
    end else begin
      $display("postfix_expression_evaluator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("postfix_expression_evaluator_core: mismatch");
    $finish;
  end

endmodule
